### rtl/wma_pkg.sv
`default_nettype none

package wma_pkg;

	// item operation codes
	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	// sequencer states, one-hot
	typedef enum logic [7:0] {
		S_INIT = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_MEM  = 8'b0000_0100,
		S_LOAD = 8'b0000_1000,
		S_DIV  = 8'b0001_0000,
		S_SAT  = 8'b0010_0000,
		S_CLR  = 8'b0100_0000,
		S_PUSH = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

### rtl/windowed_moving_average.sv
`default_nettype none

// Boxcar moving average over a ring of MAX_WINDOW signed samples kept in one
// synchronous RAM. Each input item is an add (store the sample over the oldest
// slot, update the running sum and fill count, wrap the write slot at the
// window length), a read (return a stored sample walking back from the newest,
// restarting at the newest when continue_read is 0), a clear (zero everything
// but the read position and window length) or a no-op. Every item gives one
// result: fill count, average (sum / count, truncated toward zero, saturated
// to the sample range, zero when empty) and, for reads, the sample. Items are
// handled one at a time. An add runs the restoring divider that retires one
// quotient bit per cycle; a read or no-op needs one RAM read. The average is
// cached, so only adds divide. A clear, and also the start after reset, sweeps
// the RAM writing zeros one entry per cycle, with in_stall high throughout;
// window_length writes are taken at any time but must only be made while the
// block is idle. A finished result sits in the output register and the block
// takes the next item while it waits.
module windowed_moving_average #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration: window length
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [$clog2(MAX_WINDOW+1)-1:0]     window_length,
	// input items
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          mode,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample,
	input  wire logic                                continue_read,
	// result items
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [$clog2(MAX_WINDOW+1)-1:0]     fill_count,
	output logic signed [SAMPLE_BITS-1:0]            average,
	output logic signed [SAMPLE_BITS-1:0]            read_sample
);

	localparam int AW  = $clog2(MAX_WINDOW);       // ring address
	localparam int CW  = $clog2(MAX_WINDOW + 1);   // counts up to MAX_WINDOW
	localparam int SB  = SAMPLE_BITS;
	localparam int SW  = SAMPLE_BITS + AW;         // running sum
	localparam int DCW = $clog2(SW);               // divider step counter

	// saturation bounds at sum width + 1
	localparam logic [SW:0] SAT_HI = {{(SW-SB+2){1'b0}}, {(SB-1){1'b1}}};
	localparam logic [SW:0] SAT_LO = {{(SW-SB+2){1'b1}}, {(SB-1){1'b0}}};

	wma_pkg::state_t state_q;
	wma_pkg::mode_t  op_q;
	wma_pkg::mode_t  mode_in;

	logic [CW-1:0]        n_q;        // clamped window length
	logic [AW-1:0]        wp_q;
	logic [AW-1:0]        rdpos_q;
	logic [CW-1:0]        held_q;
	logic signed [SW-1:0] sum_q;
	logic [SB-1:0]        avg_q;      // cached average
	logic [SB-1:0]        sample_q;
	logic [SB-1:0]        rd_q;
	logic [AW-1:0]        clr_idx_q;

	// divider
	logic [SW-1:0]  quo_q;
	logic [CW-1:0]  rem_q;
	logic           neg_q;
	logic [DCW-1:0] div_cnt_q;

	// output register
	logic          out_valid_q;
	logic [CW-1:0] out_fill_q;
	logic [SB-1:0] out_avg_q;
	logic [SB-1:0] out_rd_q;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [SB-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [SB-1:0] ram_rdata;

	logic          accept;
	logic          push_ok;
	logic          push_fire;
	logic [AW-1:0] n_last;
	logic [AW-1:0] wp_prev;
	logic [AW-1:0] rp_cur;
	logic [AW-1:0] rp_next;
	logic [CW-1:0] wp_inc;
	logic [AW-1:0] wp_next;
	logic [CW-1:0] n_clamp;
	logic signed [SW-1:0] sum_next;
	logic [SW-1:0] sum_mag;
	logic [CW:0]   trial;
	logic [CW:0]   diff;
	logic          trial_ge;
	logic [SW:0]   quo_signed;
	logic [SB-1:0] avg_sat;

	assign mode_in   = wma_pkg::mode_t'(mode);
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != wma_pkg::S_IDLE);
	assign accept    = in_valid && (state_q == wma_pkg::S_IDLE);
	assign push_ok   = !out_valid_q || !out_stall;
	assign push_fire = (state_q == wma_pkg::S_PUSH) && push_ok;

	assign n_clamp = (window_length == '0) ? CW'(1) :
		(window_length > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : window_length;

	// ring position arithmetic
	assign n_last  = AW'(n_q - CW'(1));
	assign wp_prev = (wp_q == '0) ? n_last : wp_q - AW'(1);
	assign rp_cur  = continue_read ? rdpos_q : wp_prev;
	assign rp_next = (rp_cur == '0) ? n_last : rp_cur - AW'(1);
	assign wp_inc  = CW'(wp_q) + CW'(1);
	assign wp_next = (wp_inc >= n_q) ? '0 : wp_inc[AW-1:0];

	// new sum: add sample, drop the overwritten one
	assign sum_next = sum_q + $signed({{AW{sample_q[SB-1]}}, sample_q})
		- $signed({{AW{ram_rdata[SB-1]}}, ram_rdata});
	assign sum_mag  = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

	// one restoring divide step
	assign trial    = {rem_q, quo_q[SW-1]};
	assign trial_ge = (trial >= {1'b0, held_q});
	assign diff     = trial - {1'b0, held_q};

	// sign and saturate the quotient
	assign quo_signed = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
	always_comb begin
		if ($signed(quo_signed) > $signed(SAT_HI)) begin
			avg_sat = SAT_HI[SB-1:0];
		end else if ($signed(quo_signed) < $signed(SAT_LO)) begin
			avg_sat = SAT_LO[SB-1:0];
		end else begin
			avg_sat = quo_signed[SB-1:0];
		end
	end

	// RAM access: sweeps write zeros, adds write the new sample in S_MEM
	always_comb begin
		ram_raddr = (mode_in == wma_pkg::MODE_READ) ? rp_cur : wp_q;
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = sample_q;
		if ((state_q == wma_pkg::S_INIT) || (state_q == wma_pkg::S_CLR)) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = '0;
		end else if ((state_q == wma_pkg::S_MEM) && (op_q == wma_pkg::MODE_ADD)) begin
			ram_we = 1'b1;
		end
	end

	wma_ram #(
		.WIDTH (SB),
		.DEPTH (MAX_WINDOW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wma_pkg::S_INIT;
			op_q        <= wma_pkg::MODE_NOP;
			n_q         <= CW'(MAX_WINDOW);
			wp_q        <= '0;
			rdpos_q     <= '0;
			held_q      <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			sample_q    <= '0;
			rd_q        <= '0;
			clr_idx_q   <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			neg_q       <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_fill_q  <= '0;
			out_avg_q   <= '0;
			out_rd_q    <= '0;
		end else begin
			if (cfg_valid) begin
				n_q <= n_clamp;
			end

			// output register: load on push, drop once taken
			if (push_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				wma_pkg::S_INIT: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					if (clr_idx_q == AW'(MAX_WINDOW - 1)) begin
						state_q <= wma_pkg::S_IDLE;
					end
				end
				wma_pkg::S_IDLE: begin
					if (accept) begin
						op_q     <= mode_in;
						sample_q <= sample;
						rd_q     <= '0;
						case (mode_in)
							wma_pkg::MODE_READ: begin
								rdpos_q <= rp_next;
								state_q <= wma_pkg::S_MEM;
							end
							wma_pkg::MODE_CLEAR: begin
								wp_q      <= '0;
								held_q    <= '0;
								sum_q     <= '0;
								avg_q     <= '0;
								clr_idx_q <= '0;
								state_q   <= wma_pkg::S_CLR;
							end
							default: begin
								state_q <= wma_pkg::S_MEM;
							end
						endcase
					end
				end
				wma_pkg::S_MEM: begin
					// read data for the item's address is valid here
					if (op_q == wma_pkg::MODE_ADD) begin
						sum_q <= sum_next;
						wp_q  <= wp_next;
						if (held_q < n_q) begin
							held_q <= held_q + CW'(1);
						end
						state_q <= wma_pkg::S_LOAD;
					end else begin
						if (op_q == wma_pkg::MODE_READ) begin
							rd_q <= ram_rdata;
						end
						state_q <= wma_pkg::S_PUSH;
					end
				end
				wma_pkg::S_LOAD: begin
					quo_q     <= sum_mag;
					neg_q     <= sum_q[SW-1];
					rem_q     <= '0;
					div_cnt_q <= DCW'(SW - 1);
					state_q   <= wma_pkg::S_DIV;
				end
				wma_pkg::S_DIV: begin
					quo_q     <= {quo_q[SW-2:0], trial_ge};
					rem_q     <= trial_ge ? diff[CW-1:0] : trial[CW-1:0];
					div_cnt_q <= div_cnt_q - DCW'(1);
					if (div_cnt_q == '0) begin
						state_q <= wma_pkg::S_SAT;
					end
				end
				wma_pkg::S_SAT: begin
					avg_q   <= avg_sat;
					state_q <= wma_pkg::S_PUSH;
				end
				wma_pkg::S_CLR: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					if (clr_idx_q == AW'(MAX_WINDOW - 1)) begin
						state_q <= wma_pkg::S_PUSH;
					end
				end
				wma_pkg::S_PUSH: begin
					if (push_ok) begin
						out_fill_q <= held_q;
						out_avg_q  <= avg_q;
						out_rd_q   <= rd_q;
						state_q    <= wma_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= wma_pkg::S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign fill_count  = out_fill_q;
	assign average     = out_avg_q;
	assign read_sample = out_rd_q;

`ifndef SYNTHESIS
	// an empty ring holds a zero sum and a zero cached average
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == '0) |-> ((sum_q == '0) && (avg_q == '0)))
		else $error("empty ring with nonzero sum or average");

	// the fill count never passes the ring depth
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(MAX_WINDOW))
		else $error("fill count beyond ring depth");

	// a new result only comes from the push step
	a_push_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == wma_pkg::S_PUSH))
		else $error("result raised outside push step");

	// the divider always runs its full count into saturation
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == wma_pkg::S_DIV) && (div_cnt_q == '0)) |=> (state_q == wma_pkg::S_SAT))
		else $error("divider did not finish into saturation");
`endif

endmodule

`default_nettype wire

### rtl/wma_ram.sv
`default_nettype none

module wma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
